// ----- rtl/hashed_name_lookup_core_assert.svh -----
// Assertion macros used by the checker file of the name lookup block.
// Needs nothing else; each macro expands to one concurrent assertion.
`ifndef HASHED_NAME_LOOKUP_CORE_ASSERT_SVH
`define HASHED_NAME_LOOKUP_CORE_ASSERT_SVH

// A property that is checked on every rising edge outside reset.
`define HNL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A valid that stays high until its item is taken.
`define HNL_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> vld) else $error(msg);

`endif

// ----- rtl/hnl_pkg.sv -----
// Package of the name lookup block: field widths, mode codes, defaults,
// the controller command and status structs and the case folding function.
package hnl_pkg;

  localparam int BASE_SIZE_DEF     = 511;
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int MAX_NAME_DEF      = 32;

  localparam int MODE_W  = 2;
  localparam int INDEX_W = 10;
  localparam int POS_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 6;
  localparam int LINK_W  = 10;
  localparam int TAG_W   = 9;
  localparam int META_W  = 1 + LEN_W + LINK_W + TAG_W;

  localparam logic [MODE_W-1:0] MODE_NAME_CHAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_METADATA  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

  // Actions that the controller requests from the datapath.
  typedef struct packed {
    logic clear_step;
    logic take;
    logic mul1;
    logic mul2;
    logic mod_step;
    logic walk_init;
    logic meta_rd;
    logic next_link;
    logic cmp_init;
    logic cmp_rd;
    logic cmp_next;
    logic hit;
    logic miss;
    logic out_load;
  } hnl_cmd_t;

  // Conditions that the datapath reports to the controller.
  typedef struct packed {
    logic clear_last;
    logic start_lookup;
    logic query_bad;
    logic mod_last;
    logic idx_bad;
    logic steps_full;
    logic m_valid;
    logic len_eq;
    logic len_gt;
    logic char_eq;
    logic pos_last;
    logic out_free;
  } hnl_sts_t;

  // Folds upper case ASCII letters to lower case; other bytes pass unchanged.
  function automatic logic [CHAR_W-1:0] lower_byte(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- rtl/hnl_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on hnl_pkg for the field widths.
interface hnl_in_if;
  import hnl_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [INDEX_W-1:0]  entry_index;
  logic [POS_W-1:0]    char_position;
  logic [CHAR_W-1:0]   char_value;
  logic                valid_in;
  logic [LEN_W-1:0]    length_in;
  logic [LINK_W-1:0]   link_in;
  logic [TAG_W-1:0]    tag_in;
  logic                query_last;

  modport source (output valid, mode, entry_index, char_position, char_value, valid_in,
                  length_in, link_in, tag_in, query_last, input ready);
  modport sink (input valid, mode, entry_index, char_position, char_value, valid_in,
                length_in, link_in, tag_in, query_last, output ready);
endinterface

interface hnl_out_if;
  import hnl_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [TAG_W-1:0]   tag_id;
  logic [INDEX_W-1:0] match_entry;

  modport source (output valid, found, tag_id, match_entry, input ready);
  modport sink (input valid, found, tag_id, match_entry, output ready);
endinterface

// ----- rtl/hnl_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Stands alone; no package needed.
module hnl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; the read data holds while no read is made.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hnl_ctrl.sv -----
// Controller state machine of the name lookup block.
// Depends on hnl_pkg for the command and status structs.
module hnl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hnl_pkg::hnl_sts_t sts_i,
  output hnl_pkg::hnl_cmd_t cmd_o
);
  import hnl_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_MUL1  = 11'b00000000100,
    S_MUL2  = 11'b00000001000,
    S_MOD   = 11'b00000010000,
    S_WALK  = 11'b00000100000,
    S_FETCH = 11'b00001000000,
    S_META  = 11'b00010000000,
    S_CRD   = 11'b00100000000,
    S_CCHK  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.start_lookup) begin
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        if (sts_i.query_bad) begin
          cmd_o.miss = 1'b1;
          state_d    = S_DONE;
        end else begin
          cmd_o.mul1 = 1'b1;
          state_d    = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk_init = 1'b1;
        state_d         = S_FETCH;
      end
      S_FETCH: begin
        if (sts_i.idx_bad || sts_i.steps_full) begin
          cmd_o.miss = 1'b1;
          state_d    = S_DONE;
        end else begin
          cmd_o.meta_rd = 1'b1;
          state_d       = S_META;
        end
      end
      S_META: begin
        if (!sts_i.m_valid || sts_i.len_gt) begin
          cmd_o.miss = 1'b1;
          state_d    = S_DONE;
        end else if (sts_i.len_eq) begin
          cmd_o.cmp_init = 1'b1;
          state_d        = S_CRD;
        end else begin
          cmd_o.next_link = 1'b1;
          state_d         = S_FETCH;
        end
      end
      S_CRD: begin
        cmd_o.cmp_rd = 1'b1;
        state_d      = S_CCHK;
      end
      S_CCHK: begin
        if (!sts_i.char_eq) begin
          cmd_o.next_link = 1'b1;
          state_d         = S_FETCH;
        end else if (sts_i.pos_last) begin
          cmd_o.hit = 1'b1;
          state_d   = S_DONE;
        end else begin
          cmd_o.cmp_next = 1'b1;
          state_d        = S_CRD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/hnl_dp.sv -----
// Datapath of the name lookup block: table and query memories, bucket
// arithmetic, chain walk registers and the result register. Uses hnl_pkg, hnl_ram.
module hnl_dp #(
  parameter int BASE_SIZE     = hnl_pkg::BASE_SIZE_DEF,
  parameter int TABLE_ENTRIES = hnl_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_NAME      = hnl_pkg::MAX_NAME_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [hnl_pkg::MODE_W-1:0]   mode_i,
  input  logic [hnl_pkg::INDEX_W-1:0]  entry_index_i,
  input  logic [hnl_pkg::POS_W-1:0]    char_position_i,
  input  logic [hnl_pkg::CHAR_W-1:0]   char_value_i,
  input  logic                         valid_in_i,
  input  logic [hnl_pkg::LEN_W-1:0]    length_in_i,
  input  logic [hnl_pkg::LINK_W-1:0]   link_in_i,
  input  logic [hnl_pkg::TAG_W-1:0]    tag_in_i,
  input  logic                         query_last_i,
  input  hnl_pkg::hnl_cmd_t            cmd_i,
  output hnl_pkg::hnl_sts_t            sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [hnl_pkg::TAG_W-1:0]    tag_id_o,
  output logic [hnl_pkg::INDEX_W-1:0]  match_entry_o
);
  import hnl_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int NAME_W  = $clog2(MAX_NAME);
  localparam int CNT_W   = $clog2(MAX_NAME + 1);
  localparam int CA_W    = $clog2(TABLE_ENTRIES * MAX_NAME);
  localparam int PROD_W  = 2 * CHAR_W + CNT_W;
  localparam int MB_W    = 2;
  localparam int REM_W   = $clog2(BASE_SIZE + 1);
  localparam int STEP_W  = $clog2(TABLE_ENTRIES + 1);
  // Reciprocal of BASE_SIZE, exact for every product of PROD_W bits.
  localparam int BASE_LG = $clog2(BASE_SIZE);
  localparam int RS_W    = PROD_W + BASE_LG;
  localparam int RCP_W   = PROD_W + 2;
  localparam int QP_W    = PROD_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RS_W) + 64'(BASE_SIZE) - 64'd1) / 64'(BASE_SIZE));

  // Query capture state.
  logic [CNT_W-1:0]    count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [CHAR_W-1:0]   first_q, last_q;
  logic [CNT_W-1:0]    len_q;
  logic                bad_q;
  // Bucket arithmetic.
  logic [2*CHAR_W-1:0] p1_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   quo_q;
  logic [REM_W-1:0]    rem_q;
  logic [MB_W-1:0]     mcnt_q;
  logic [QP_W-1:0]     qprod;
  // Chain walk.
  logic [LINK_W-1:0]   idx_q;
  logic [STEP_W-1:0]   steps_q;
  logic [NAME_W-1:0]   pos_q;
  logic [IDX_W-1:0]    clr_q;
  // Result.
  logic                res_found_q;
  logic [TAG_W-1:0]    res_tag_q;
  logic [INDEX_W-1:0]  res_entry_q;
  logic                out_valid_q;
  logic                out_found_q;
  logic [TAG_W-1:0]    out_tag_q;
  logic [INDEX_W-1:0]  out_entry_q;

  logic                take_char, take_meta, take_query, q_room;
  logic [CHAR_W-1:0]   ch_lc;
  logic                meta_we;
  logic [IDX_W-1:0]    meta_waddr;
  logic [META_W-1:0]   meta_wdata, meta_rdata;
  logic                m_valid;
  logic [LEN_W-1:0]    m_len;
  logic [LINK_W-1:0]   m_link;
  logic [TAG_W-1:0]    m_tag;
  logic [CA_W-1:0]     char_waddr, char_raddr;
  logic [CHAR_W-1:0]   char_rdata, q_rdata;

  assign ch_lc      = lower_byte(char_value_i);
  assign take_char  = cmd_i.take && mode_i == MODE_NAME_CHAR
                      && entry_index_i < TABLE_ENTRIES && char_position_i < MAX_NAME;
  assign take_meta  = cmd_i.take && mode_i == MODE_METADATA
                      && entry_index_i < TABLE_ENTRIES;
  assign take_query = cmd_i.take && mode_i == MODE_QUERY;
  assign q_room     = count_q < CNT_W'(MAX_NAME);

  // Metadata memory: the clearing pass after reset writes invalid entries.
  assign meta_we    = cmd_i.clear_step || take_meta;
  assign meta_waddr = cmd_i.clear_step ? clr_q : IDX_W'(entry_index_i);
  assign meta_wdata = cmd_i.clear_step ? '0
                      : {valid_in_i, length_in_i, link_in_i, tag_in_i};

  hnl_ram #(.WIDTH(META_W), .DEPTH(TABLE_ENTRIES)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (cmd_i.meta_rd),
    .raddr_i (IDX_W'(idx_q)),
    .rdata_o (meta_rdata)
  );

  assign {m_valid, m_len, m_link, m_tag} = meta_rdata;

  // Name character memory, one row of MAX_NAME bytes per entry.
  assign char_waddr = CA_W'(CA_W'(IDX_W'(entry_index_i)) * CA_W'(MAX_NAME)
                      + CA_W'(char_position_i));
  assign char_raddr = CA_W'(CA_W'(IDX_W'(idx_q)) * CA_W'(MAX_NAME) + CA_W'(pos_q));

  hnl_ram #(.WIDTH(CHAR_W), .DEPTH(TABLE_ENTRIES * MAX_NAME)) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (take_char),
    .waddr_i (char_waddr),
    .wdata_i (char_value_i),
    .re_i    (cmd_i.cmp_rd),
    .raddr_i (char_raddr),
    .rdata_o (char_rdata)
  );

  // Query characters, stored folded to lower case.
  hnl_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_NAME)) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (take_query && q_room),
    .waddr_i (NAME_W'(count_q)),
    .wdata_i (ch_lc),
    .re_i    (cmd_i.cmp_rd),
    .raddr_i (pos_q),
    .rdata_o (q_rdata)
  );

  // Query count and overflow; both return to zero once the last item is in.
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (take_query) begin
      if (q_room) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (query_last_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Product with the reciprocal; its upper bits give the bucket quotient.
  assign qprod = QP_W'(prod_q) * QP_W'(RECIP);

  // Payload registers of the query, the arithmetic and the walk.
  always_ff @(posedge clk_i) begin
    if (take_query && q_room) begin
      if (count_q == '0) begin
        first_q <= ch_lc;
      end
      last_q <= ch_lc;
    end
    if (take_query && query_last_i) begin
      len_q <= q_room ? count_q + CNT_W'(1) : count_q;
      bad_q <= ovf_q || !q_room;
    end
    if (cmd_i.mul1) begin
      p1_q <= first_q * last_q;
    end
    if (cmd_i.mul2) begin
      prod_q <= PROD_W'(p1_q) * PROD_W'(len_q);
      mcnt_q <= MB_W'(3);
    end
    // Remainder in three steps: quotient, raw remainder, final correction.
    if (cmd_i.mod_step) begin
      case (mcnt_q)
        MB_W'(3): quo_q <= PROD_W'(qprod >> RS_W);
        MB_W'(2): prod_q <= prod_q - PROD_W'(quo_q * PROD_W'(BASE_SIZE));
        default: begin
          rem_q <= (prod_q >= PROD_W'(BASE_SIZE)) ? REM_W'(prod_q - PROD_W'(BASE_SIZE))
                                                  : REM_W'(prod_q);
        end
      endcase
      mcnt_q <= mcnt_q - MB_W'(1);
    end
    if (cmd_i.walk_init) begin
      idx_q   <= LINK_W'(rem_q) + LINK_W'(1);
      steps_q <= '0;
    end
    if (cmd_i.next_link) begin
      idx_q   <= m_link;
      steps_q <= steps_q + STEP_W'(1);
    end
    if (cmd_i.cmp_init) begin
      pos_q <= '0;
    end
    if (cmd_i.cmp_next) begin
      pos_q <= pos_q + NAME_W'(1);
    end
    if (cmd_i.hit) begin
      res_found_q <= 1'b1;
      res_tag_q   <= m_tag;
      res_entry_q <= idx_q;
    end
    if (cmd_i.miss) begin
      res_found_q <= 1'b0;
      res_tag_q   <= '0;
      res_entry_q <= '0;
    end
    if (cmd_i.out_load) begin
      out_found_q <= res_found_q;
      out_tag_q   <= res_tag_q;
      out_entry_q <= res_entry_q;
    end
  end

  // Status towards the controller.
  always_comb begin
    sts_o              = '0;
    sts_o.clear_last   = clr_q == IDX_W'(TABLE_ENTRIES - 1);
    sts_o.start_lookup = mode_i == MODE_QUERY && query_last_i;
    sts_o.query_bad    = bad_q;
    sts_o.mod_last     = mcnt_q == MB_W'(1);
    sts_o.idx_bad      = idx_q == '0 || idx_q >= TABLE_ENTRIES;
    sts_o.steps_full   = steps_q == STEP_W'(TABLE_ENTRIES);
    sts_o.m_valid      = m_valid;
    sts_o.len_eq       = m_len == len_q;
    sts_o.len_gt       = m_len > len_q;
    sts_o.char_eq      = lower_byte(char_rdata) == q_rdata;
    sts_o.pos_last     = CNT_W'(pos_q) + CNT_W'(1) == len_q;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign tag_id_o      = out_tag_q;
  assign match_entry_o = out_entry_q;

endmodule

// ----- rtl/hashed_name_lookup_core.sv -----
// Case-insensitive name lookup in a chained hash table. Load items (entry name
// characters and entry metadata) and query characters other than the last are
// taken back to back while idle. The last query character starts a lookup:
// the product of first character, last character and length, its remainder by
// BASE_SIZE through multiplication by its reciprocal, the bucket from it, then
// a metadata memory read and check per chain entry visited and a character
// memory read and compare per name character compared, and a hand-over of the
// item to the output register once that is free. No item is accepted during a
// lookup. After reset a clearing pass invalidates the metadata memory before
// the first item is accepted. A waiting result does not block load items.
// Depends on hnl_pkg, hnl_if, hnl_ram, hnl_ctrl and hnl_dp.
module hashed_name_lookup_core #(
  parameter int BASE_SIZE     = hnl_pkg::BASE_SIZE_DEF,
  parameter int TABLE_ENTRIES = hnl_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_NAME      = hnl_pkg::MAX_NAME_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hnl_in_if.sink    in_i,
  hnl_out_if.source out_o
);
  import hnl_pkg::*;

  hnl_cmd_t cmd;
  hnl_sts_t sts;

  // Controller.
  hnl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  hnl_dp #(
    .BASE_SIZE     (BASE_SIZE),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_NAME      (MAX_NAME)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (in_i.mode),
    .entry_index_i   (in_i.entry_index),
    .char_position_i (in_i.char_position),
    .char_value_i    (in_i.char_value),
    .valid_in_i      (in_i.valid_in),
    .length_in_i     (in_i.length_in),
    .link_in_i       (in_i.link_in),
    .tag_in_i        (in_i.tag_in),
    .query_last_i    (in_i.query_last),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .found_o         (out_o.found),
    .tag_id_o        (out_o.tag_id),
    .match_entry_o   (out_o.match_entry)
  );

endmodule

// ----- rtl/hnl_checker.sv -----
// Port-level checks of the name lookup block and their bind to the top level.
// Depends on hnl_pkg and the assertion macro header.
`include "hashed_name_lookup_core_assert.svh"

module hnl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [hnl_pkg::MODE_W-1:0]  mode_i,
  input logic                        query_last_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        found_i,
  input logic [hnl_pkg::TAG_W-1:0]   tag_id_i,
  input logic [hnl_pkg::INDEX_W-1:0] match_entry_i
);
  import hnl_pkg::*;

  // A result item stays offered until it is taken.
  `HNL_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, "result dropped")

  // A miss carries zero tag and zero entry.
  `HNL_ASSERT(a_miss_zero, clk_i, rst_ni,
              (out_valid_i && !found_i) |-> (tag_id_i == '0 && match_entry_i == '0),
              "miss with non-zero payload")

  // A hit never names entry zero, which ends every chain.
  `HNL_ASSERT(a_hit_entry, clk_i, rst_ni, (out_valid_i && found_i) |-> (match_entry_i != '0),
              "hit on entry zero")

  // The last query item starts a lookup, during which no item is taken.
  `HNL_ASSERT(a_busy, clk_i, rst_ni,
              (in_valid_i && in_ready_i && mode_i == MODE_QUERY && query_last_i) |=> !in_ready_i,
              "item taken during lookup")

endmodule

bind hashed_name_lookup_core hnl_checker u_hnl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .mode_i        (in_i.mode),
  .query_last_i  (in_i.query_last),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .found_i       (out_o.found),
  .tag_id_i      (out_o.tag_id),
  .match_entry_i (out_o.match_entry)
);
